>>> design/sm3_pkg.sv
// SM3 hash engine package: constants and round helper functions.
// No dependencies.
package sm3_pkg;
  localparam int WORD_W = 32;
  localparam logic [WORD_W-1:0] IV_WORDS [8] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};
  localparam logic [WORD_W-1:0] T_LOW  = 32'h79cc4519;
  localparam logic [WORD_W-1:0] T_HIGH = 32'h7a879d8a;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

  // Control returned from the compression core to the input sequencer.
  typedef struct packed {
    logic start;
    logic busy;
  } sm3_cmp_ctl_t;
endpackage

>>> design/sm3_compress.sv
// SM3 compression core: one round per cycle, 16-word schedule window.
// Depends on sm3_pkg.
module sm3_compress
  import sm3_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,       // block words are in the block memory
  output logic [3:0]       blk_addr,    // block word read address
  input  logic [31:0]      blk_rdata,   // registered read of blk_addr, arrives the cycle after
  input  logic             init_cv,     // reload IV
  output sm3_cmp_ctl_t     ctl,
  output logic [255:0]     cv           // chaining value, word 0 high
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001, S_LOAD = 3'b010, S_RUN = 3'b100
  } cst_t;

  cst_t        st_r, st_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [31:0] cv_r [8];
  logic [31:0] r_r  [8];
  // Sliding W window: w_r[k] holds W[j+k] in round j.
  logic [31:0] w_r  [16];
  logic [31:0] wn, a12, ss1, ss2, ff, gg, tt1, tt2, tj;
  logic [5:0]  j;

  assign blk_addr = cnt_r[3:0];
  assign ctl.busy = (st_r != S_IDLE);
  assign ctl.start = start;
  assign j = cnt_r[5:0];

  // Load fills the window from the registered block read, then 64 rounds.
  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    unique case (st_r)
      S_IDLE: if (start) begin st_nxt = S_LOAD; cnt_nxt = '0; end
      S_LOAD: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd16) begin st_nxt = S_RUN; cnt_nxt = '0; end
      end
      S_RUN: begin
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Expansion of W[j+16] and the round function.
  always_comb begin
    wn  = perm1(w_r[0] ^ w_r[7] ^ rotl(w_r[13], 5'd15)) ^ rotl(w_r[3], 5'd7) ^ w_r[10];
    tj  = (j < 6'd16) ? T_LOW : T_HIGH;
    a12 = rotl(r_r[0], 5'd12);
    ss1 = rotl(a12 + r_r[4] + rotl(tj, j[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (j < 6'd16) begin
      ff = r_r[0] ^ r_r[1] ^ r_r[2];
      gg = r_r[4] ^ r_r[5] ^ r_r[6];
    end else begin
      ff = (r_r[0] & r_r[1]) | (r_r[0] & r_r[2]) | (r_r[1] & r_r[2]);
      gg = (r_r[4] & r_r[5]) | (~r_r[4] & r_r[6]);
    end
    tt1 = ff + r_r[3] + ss2 + (w_r[0] ^ w_r[4]);
    tt2 = gg + r_r[7] + ss1 + w_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      for (int i = 0; i < 8; i++) cv_r[i] <= IV_WORDS[i];
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      if (init_cv) begin
        for (int i = 0; i < 8; i++) cv_r[i] <= IV_WORDS[i];
      end else if (st_r == S_RUN && cnt_r == 7'd63) begin
        cv_r[0] <= cv_r[0] ^ tt1;
        cv_r[1] <= cv_r[1] ^ r_r[0];
        cv_r[2] <= cv_r[2] ^ rotl(r_r[1], 5'd9);
        cv_r[3] <= cv_r[3] ^ r_r[2];
        cv_r[4] <= cv_r[4] ^ perm0(tt2);
        cv_r[5] <= cv_r[5] ^ r_r[4];
        cv_r[6] <= cv_r[6] ^ rotl(r_r[5], 5'd19);
        cv_r[7] <= cv_r[7] ^ r_r[6];
      end
    end
  end

  // Window fill and round state.
  always_ff @(posedge clk) begin
    if (st_r == S_LOAD) begin
      if (cnt_r == 7'd0) begin
        for (int i = 0; i < 8; i++) r_r[i] <= cv_r[i];
      end else begin
        // word cnt_r-1 arrives; after 16 shifts w_r[i] = W[i]
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= blk_rdata;
      end
    end else if (st_r == S_RUN) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
      r_r[3] <= r_r[2];
      r_r[2] <= rotl(r_r[1], 5'd9);
      r_r[1] <= r_r[0];
      r_r[0] <= tt1;
      r_r[7] <= r_r[6];
      r_r[6] <= rotl(r_r[5], 5'd19);
      r_r[5] <= r_r[4];
      r_r[4] <= perm0(tt2);
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_cv
    assign cv[255-32*g -: 32] = cv_r[g];
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> st_r == S_IDLE) else $error("start while busy");
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RUN && cnt_r == 7'd63) |=> st_r == S_IDLE) else $error("round count");
  a_cnt_rng: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_LOAD |-> cnt_r <= 7'd16) else $error("load count");
endmodule

>>> design/sm3_hash_engine.sv
// SM3 hash engine top: byte packing into a block memory, padding sequencer,
// digest output. Depends on sm3_pkg and sm3_compress.
//
// Usage: message words enter on the in_ stream (tdata = data_word, valid
// bytes; tlast marks the last word). One word is taken at a time: the beat
// is accepted in the idle state, then its bytes pack into a 16-word block
// memory at one byte per cycle, pausing while a full block compresses, and
// only then is the next beat accepted. A byte that fills the block starts
// the compression: the core loads the block words out of the memory into
// the schedule window, runs 64 rounds at one per cycle and hands control
// back to the sequencer. The last word appends padding one byte per cycle,
// again pausing while a full block compresses, compresses once or twice
// more, and then the first digest beat comes up. Eight digest beats follow
// on out_ (tuser = word_index, tlast = last_digest), one per cycle while
// out_tready is high. No input is taken until the eighth beat is accepted;
// a stalled receiver simply holds the current beat. Reset loads the
// initial value and clears lengths; the block memory needs no clearing.
module sm3_hash_engine
  import sm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] data_word, [34:32] valid_bytes, rest zero
  input  logic        in_tlast,   // last_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_digest
);
  typedef enum logic [4:0] {
    T_IDLE = 5'b00001, T_BYTES = 5'b00010, T_PAD = 5'b00100,
    T_COMP = 5'b01000, T_OUT = 5'b10000
  } tst_t;

  tst_t         st_r, st_nxt;
  logic [31:0]  word_r;
  logic [2:0]   cnt_r;      // bytes left of current word
  logic         last_r;
  logic [5:0]   fill_r;
  logic [63:0]  blen_r;
  logic [2:0]   oidx_r;
  logic         padded_r;   // 0x80 written
  logic         len_blk_r;  // this block carries the length in bytes 56..63
  logic         fin_r;      // running compression is the final one
  logic [31:0]  mem [16];
  logic [31:0]  mem_rd_r;
  logic [31:0]  acc_r;      // partial word being assembled
  logic [3:0]   core_addr;
  logic         cstart;
  sm3_cmp_ctl_t cctl;
  logic [255:0] cv;
  logic         put;
  logic [7:0]   pbyte;
  logic [2:0]   vb;
  logic [31:0]  acc_nxt;
  logic [63:0]  len_sh;
  logic         init_cv;

  assign vb = (in_tdata[34:32] > 3'd4) ? 3'd4 : in_tdata[34:32];

  // Byte to place this cycle.
  always_comb begin
    put = 1'b0;
    pbyte = 8'h00;
    len_sh = blen_r << {fill_r[2:0], 3'b000};
    if (st_r == T_BYTES) begin
      put = (cnt_r != 3'd0);
      pbyte = word_r[31:24];
    end else if (st_r == T_PAD) begin
      put = 1'b1;
      if (!padded_r) pbyte = PAD_BYTE;
      else if (len_blk_r && fill_r >= 6'd56) pbyte = len_sh[63:56];
    end
    acc_nxt = {acc_r[23:0], pbyte};
  end

  // Sequencer: bytes, padding, compression handoff, digest beats.
  always_comb begin
    st_nxt = st_r;
    cstart = 1'b0;
    init_cv = 1'b0;
    unique case (st_r)
      T_IDLE: if (in_tvalid) st_nxt = T_BYTES;
      T_BYTES: begin
        if (cnt_r == 3'd0) st_nxt = last_r ? T_PAD : T_IDLE;
        else if (fill_r == 6'd63) begin cstart = 1'b1; st_nxt = T_COMP; end
        else if (cnt_r == 3'd1) st_nxt = last_r ? T_PAD : T_IDLE;
      end
      T_PAD: begin
        if (fill_r == 6'd63) begin cstart = 1'b1; st_nxt = T_COMP; end
      end
      T_COMP: begin
        if (!cctl.busy) begin
          if (fin_r) st_nxt = T_OUT;
          else if (cnt_r != 3'd0) st_nxt = T_BYTES;
          else if (last_r) st_nxt = T_PAD;
          else st_nxt = T_IDLE;
        end
      end
      T_OUT: if (out_tready && oidx_r == 3'd7) begin
        st_nxt = T_IDLE; init_cv = 1'b1;
      end
      default: st_nxt = T_IDLE;
    endcase
  end

  assign in_tready = (st_r == T_IDLE);

  // Block memory: one word write, core reads through its own address.
  always_ff @(posedge clk) begin
    if (put && fill_r[1:0] == 2'd3) mem[fill_r[5:2]] <= acc_nxt;
    mem_rd_r <= mem[core_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= T_IDLE; fill_r <= '0; blen_r <= '0; oidx_r <= '0;
      padded_r <= 1'b0; cnt_r <= '0; last_r <= 1'b0;
      len_blk_r <= 1'b0; fin_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == T_IDLE && in_tvalid) begin
        word_r <= in_tdata[31:0];
        cnt_r <= vb;
        last_r <= in_tlast;
        blen_r <= blen_r + {58'd0, vb, 3'd0};
      end
      if (put) begin
        acc_r <= acc_nxt;
        fill_r <= fill_r + 6'd1;
        if (st_r == T_BYTES) begin
          word_r <= {word_r[23:0], 8'h00};
          cnt_r <= cnt_r - 3'd1;
        end
        if (st_r == T_PAD) begin
          padded_r <= 1'b1;
          // pad byte past byte 55 pushes the length into the next block
          if (fill_r == 6'd63) len_blk_r <= 1'b1;
          else if (!padded_r) len_blk_r <= (fill_r < 6'd56);
          fin_r <= padded_r && len_blk_r && (fill_r == 6'd63);
        end
      end
      if (st_r == T_OUT && out_tready) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd7) begin
          blen_r <= '0; padded_r <= 1'b0; last_r <= 1'b0;
          len_blk_r <= 1'b0; fin_r <= 1'b0;
        end
      end
    end
  end

  sm3_compress u_cmp (
    .clk(clk), .rst_n(rst_n), .start(cstart), .blk_addr(core_addr),
    .blk_rdata(mem_rd_r), .init_cv(init_cv), .ctl(cctl), .cv(cv));

  assign out_tvalid = (st_r == T_OUT);
  assign out_tdata  = cv[255 - 32*oidx_r -: 32];
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == 3'd7);

  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cctl.busy |-> !in_tready) else $error("input taken during compression");
  a_out_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tuser)) else $error("index moved");
  a_fill_word: assert property (@(posedge clk) disable iff (!rst_n)
    cstart |-> fill_r == 6'd63) else $error("start on partial block");
endmodule
